@@ sv/asc_pkg.sv @@
`default_nettype none
package asc_pkg;

   localparam int SITE_ENTRIES = 256;
   localparam int ADDR_ENTRIES = 1024;
   localparam int PROBE_WAYS   = 4;

   localparam int SBITS = $clog2(SITE_ENTRIES);
   localparam int ABITS = $clog2(ADDR_ENTRIES);
   localparam int IBITS = (SBITS > ABITS) ? SBITS : ABITS;
   localparam int WBITS = $clog2(PROBE_WAYS + 1);

   // mixed hash: only the low HBITS of the product feed the table indexes
   localparam int HBITS = 32 + IBITS;
   localparam int HALF  = (HBITS + 1) / 2;
   localparam logic [63:0] MIX_MUL = 64'h9E3779B97F4A7C15;

   localparam int CLR_ENTRIES = (SITE_ENTRIES > ADDR_ENTRIES) ? SITE_ENTRIES : ADDR_ENTRIES;
   localparam int CLRW        = $clog2(CLR_ENTRIES) + 1;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      STS_RECORDED = 3'd0,
      STS_IGNORED  = 3'd1,
      STS_FREE_HIT = 3'd2,
      STS_UNKNOWN  = 3'd3,
      STS_STALE    = 3'd4,
      STS_FULL     = 3'd5
   } sts_type;

   typedef struct packed {
      logic [31:0] live_count;
      logic [47:0] live_bytes;
      logic [31:0] total_count;
      logic [47:0] total_bytes;
   } cnt_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] addr;
   } tag_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] hash;
   } key_type;

   typedef struct packed {
      logic [SBITS-1:0] site;
      logic [31:0]      size;
      logic [30:0]      seq;
   } info_type;

   // credit one block of the given size, saturating every counter
   function automatic cnt_type cnt_credit(cnt_type c, logic [31:0] size);
      cnt_type     r;
      logic [48:0] lb;
      logic [48:0] tb;
      r  = c;
      lb = {1'b0, c.live_bytes} + 49'(size);
      tb = {1'b0, c.total_bytes} + 49'(size);
      r.live_bytes  = lb[48] ? MAX48 : lb[47:0];
      r.total_bytes = tb[48] ? MAX48 : tb[47:0];
      r.live_count  = (c.live_count == MAX32) ? MAX32 : c.live_count + 32'd1;
      r.total_count = (c.total_count == MAX32) ? MAX32 : c.total_count + 32'd1;
      return r;
   endfunction

   // debit one block, never going below zero
   function automatic cnt_type cnt_debit(cnt_type c, logic [31:0] size);
      cnt_type r;
      r = c;
      if (c.live_count != 32'd0) r.live_count = c.live_count - 32'd1;
      if (c.live_bytes >= 48'(size)) r.live_bytes = c.live_bytes - 48'(size);
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/asc_if.sv @@
`default_nettype none
interface asc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [63:0] address;
   logic [31:0] alloc_size;
   logic [63:0] site_hash;
   logic [5:0]  frame_count;
   logic [30:0] sequence_req;

   modport source (output valid, action, address, alloc_size, site_hash, frame_count,
                   sequence_req, input ready);
   modport sink (input valid, action, address, alloc_size, site_hash, frame_count,
                 sequence_req, output ready);
endinterface

interface asc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        reclaimed_old;
   logic [31:0] site_live_count;
   logic [47:0] site_live_bytes;
   logic [31:0] site_total_count;
   logic [47:0] site_total_bytes;

   modport source (output valid, status, reclaimed_old, site_live_count, site_live_bytes,
                   site_total_count, site_total_bytes, input ready);
   modport sink (input valid, status, reclaimed_old, site_live_count, site_live_bytes,
                 site_total_count, site_total_bytes, output ready);
endinterface
`default_nettype wire

@@ sv/asc_mix.sv @@
`default_nettype none
module asc_mix import asc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [63:0]       key,
   output logic                   done,
   output logic [HBITS-1:0]       mixed
);

   typedef enum logic [1:0] {M_IDLE, M_LOW, M_MID, M_HIGH} mst_type;

   localparam logic [HALF-1:0] C_LO = MIX_MUL[HALF-1:0];
   localparam logic [HALF-1:0] C_HI = MIX_MUL[2*HALF-1:HALF];

   mst_type            mst_ff;
   logic [2*HALF-1:0]  x_ff;
   logic [2*HALF-1:0]  acc_ff;
   logic               done_ff;
   logic [63:0]        xk;
   logic [2*HALF-1:0]  prod;
   logic [HALF-1:0]    mul_a;
   logic [HALF-1:0]    mul_b;

   assign xk = key ^ (key >> 29);

   // one partial product a cycle
   always_comb begin
      mul_a = x_ff[HALF-1:0];
      mul_b = C_LO;
      case (mst_ff)
         M_MID:   mul_a = x_ff[2*HALF-1:HALF];
         M_HIGH:  mul_b = C_HI;
         default: ;
      endcase
   end

   assign prod = (2*HALF)'(mul_a) * (2*HALF)'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         mst_ff  <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (mst_ff)
            M_IDLE: if (start) begin
               x_ff   <= (2*HALF)'(xk[HBITS-1:0]);
               mst_ff <= M_LOW;
            end
            M_LOW: begin
               acc_ff <= prod;
               mst_ff <= M_MID;
            end
            M_MID: begin
               acc_ff <= acc_ff + {prod[HALF-1:0], {HALF{1'b0}}};
               mst_ff <= M_HIGH;
            end
            M_HIGH: begin
               acc_ff  <= acc_ff + {prod[HALF-1:0], {HALF{1'b0}}};
               done_ff <= 1'b1;
               mst_ff  <= M_IDLE;
            end
            default: mst_ff <= M_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign mixed = acc_ff[HBITS-1:0];

endmodule
`default_nettype wire

@@ sv/alloc_site_accounting_top.sv @@
`default_nettype none
// An allocation runs both hash passes, both probes, ST_AFIT, ST_AUPD and ST_ADEBIT when
// it displaces a block; a free runs one hash pass, one probe, ST_FCHECK to ST_FUPD; an
// ignored allocation or a free of address zero goes straight to ST_DONE. Throughput:
// one event at a time; the hash unit and the one-read-per-cycle table probes bound it.
// Reset: synchronous; after reset a clearing pass over max(SITE_ENTRIES, ADDR_ENTRIES)
// entries (1024) invalidates both tables, and no event is taken meanwhile.
module alloc_site_accounting_top import asc_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   asc_req_if.sink    req_chan,
   asc_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_AMIX, ST_SMIX, ST_APROBE, ST_SPROBE, ST_AFIT, ST_AUPD,
      ST_ADEBIT, ST_FCHECK, ST_FCNT, ST_FUPD, ST_DONE
   } state_type;

   typedef struct packed {
      tag_type  tag;
      info_type info;
   } arow_type;

   typedef struct packed {
      key_type  key;
      cnt_type  cnt;
   } srow_type;

   // memories: address table with block info, site table with counters
   arow_type amem [ADDR_ENTRIES];
   srow_type smem [SITE_ENTRIES];

   arow_type ard_ff;
   srow_type srd_ff;

   logic             a_we, s_we;
   logic [ABITS-1:0] a_wa, a_ra;
   logic [SBITS-1:0] s_wa, s_ra;
   arow_type         a_wd;
   srow_type         s_wd;

   // control and held item
   state_type        state_ff, state_in;
   logic             act_ff, act_in;
   logic [63:0]      addr_ff, addr_in;
   logic [31:0]      size_ff, size_in;
   logic [63:0]      hash_ff, hash_in;
   logic [30:0]      seq_ff, seq_in;
   logic [ABITS-1:0] abase_ff, abase_in;
   logic [SBITS-1:0] sbase_ff, sbase_in;
   logic [WBITS-1:0] way_ff, way_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             cmp_last_ff, cmp_last_in;
   logic [ABITS-1:0] cmp_aidx_ff, cmp_aidx_in;
   logic [SBITS-1:0] cmp_sidx_ff, cmp_sidx_in;
   logic             amatch_ff, amatch_in, afound_ff, afound_in;
   logic [ABITS-1:0] aidx_ff, aidx_in, afree_ff, afree_in;
   logic             smatch_ff, smatch_in, sfound_ff, sfound_in;
   logic [SBITS-1:0] sidx_ff, sidx_in, sfree_ff, sfree_in;
   logic [SBITS-1:0] old_site_ff, old_site_in;
   logic [31:0]      old_size_ff, old_size_in;
   logic [30:0]      old_seq_ff, old_seq_in;
   cnt_type          cnt_s_ff, cnt_s_in;
   sts_type          res_sts_ff, res_sts_in;
   logic             res_recl_ff, res_recl_in;
   cnt_type          res_cnt_ff, res_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sts_type          rsp_sts_ff, rsp_sts_in;
   logic             rsp_recl_ff, rsp_recl_in;
   cnt_type          rsp_cnt_ff, rsp_cnt_in;
   logic [CLRW-1:0]  clr_ff, clr_in;

   logic             mix_start, mix_done;
   logic [63:0]      mix_key;
   logic [HBITS-1:0] mix_out;
   logic             req_beat;
   logic [SBITS-1:0] s_sel;
   logic [ABITS-1:0] a_sel;
   cnt_type          crd_cnt, dbt_alloc, dbt_free;

   asc_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (mix_key),
      .done  (mix_done),
      .mixed (mix_out)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;

   assign s_sel = smatch_ff ? sidx_ff : sfree_ff;
   assign a_sel = amatch_ff ? aidx_ff : afree_ff;

   assign crd_cnt   = cnt_credit(smatch_ff ? srd_ff.cnt : '0, size_ff);
   assign dbt_alloc = cnt_debit((old_site_ff == s_sel) ? cnt_s_ff : srd_ff.cnt, old_size_ff);
   assign dbt_free  = cnt_debit(srd_ff.cnt, old_size_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      addr_in     = addr_ff;
      size_in     = size_ff;
      hash_in     = hash_ff;
      seq_in      = seq_ff;
      abase_in    = abase_ff;
      sbase_in    = sbase_ff;
      way_in      = way_ff;
      cmp_vld_in  = 1'b0;
      cmp_last_in = cmp_last_ff;
      cmp_aidx_in = cmp_aidx_ff;
      cmp_sidx_in = cmp_sidx_ff;
      amatch_in   = amatch_ff;
      afound_in   = afound_ff;
      aidx_in     = aidx_ff;
      afree_in    = afree_ff;
      smatch_in   = smatch_ff;
      sfound_in   = sfound_ff;
      sidx_in     = sidx_ff;
      sfree_in    = sfree_ff;
      old_site_in = old_site_ff;
      old_size_in = old_size_ff;
      old_seq_in  = old_seq_ff;
      cnt_s_in    = cnt_s_ff;
      res_sts_in  = res_sts_ff;
      res_recl_in = res_recl_ff;
      res_cnt_in  = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sts_in  = rsp_sts_ff;
      rsp_recl_in = rsp_recl_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      clr_in      = clr_ff;
      mix_start   = 1'b0;
      mix_key     = hash_ff;
      a_we = 1'b0; a_wa = '0; a_wd = '0; a_ra = '0;
      s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;

      // drop the result register once its beat is taken
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff < CLRW'(ADDR_ENTRIES)) begin
               a_we = 1'b1;
               a_wa = clr_ff[ABITS-1:0];
            end
            if (clr_ff < CLRW'(SITE_ENTRIES)) begin
               s_we = 1'b1;
               s_wa = clr_ff[SBITS-1:0];
            end
            clr_in = clr_ff + CLRW'(1);
            if (clr_ff == CLRW'(CLR_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (req_beat) begin
            act_in    = req_chan.action;
            addr_in   = req_chan.address;
            size_in   = req_chan.alloc_size;
            hash_in   = req_chan.site_hash;
            seq_in    = req_chan.sequence_req;
            way_in    = '0;
            amatch_in = 1'b0;
            afound_in = 1'b0;
            smatch_in = 1'b0;
            sfound_in = 1'b0;
            res_recl_in = 1'b0;
            res_cnt_in  = '0;
            if (!req_chan.action &&
                (req_chan.frame_count == 6'd0 || req_chan.site_hash == 64'd0)) begin
               res_sts_in = STS_IGNORED;
               state_in   = ST_DONE;
            end else if (req_chan.action && req_chan.address == 64'd0) begin
               res_sts_in = STS_UNKNOWN;
               state_in   = ST_DONE;
            end else begin
               mix_start = 1'b1;
               mix_key   = req_chan.address;
               state_in  = ST_AMIX;
            end
         end
         ST_AMIX: if (mix_done) begin
            abase_in = mix_out[ABITS-1:0] ^ mix_out[32+ABITS-1:32];
            if (!act_ff) begin
               mix_start = 1'b1;
               state_in  = ST_SMIX;
            end else begin
               state_in = ST_APROBE;
            end
         end
         ST_SMIX: if (mix_done) begin
            sbase_in = mix_out[SBITS-1:0] ^ mix_out[32+SBITS-1:32];
            state_in = ST_APROBE;
         end
         ST_APROBE: begin
            // issue one way a cycle, compare the way read the cycle before
            if (way_ff < WBITS'(PROBE_WAYS)) begin
               a_ra        = abase_ff + ABITS'(way_ff);
               cmp_aidx_in = a_ra;
               cmp_vld_in  = 1'b1;
               cmp_last_in = (way_ff == WBITS'(PROBE_WAYS - 1));
               way_in      = way_ff + WBITS'(1);
            end
            if (cmp_vld_ff) begin
               if (ard_ff.tag.valid && ard_ff.tag.addr == addr_ff && !amatch_ff) begin
                  amatch_in = 1'b1;
                  aidx_in   = cmp_aidx_ff;
               end
               if (!ard_ff.tag.valid && !afound_ff) begin
                  afound_in = 1'b1;
                  afree_in  = cmp_aidx_ff;
               end
               if (cmp_last_ff) begin
                  way_in   = '0;
                  state_in = act_ff ? ST_FCHECK : ST_SPROBE;
               end
            end
         end
         ST_SPROBE: begin
            if (way_ff < WBITS'(PROBE_WAYS)) begin
               s_ra        = sbase_ff + SBITS'(way_ff);
               cmp_sidx_in = s_ra;
               cmp_vld_in  = 1'b1;
               cmp_last_in = (way_ff == WBITS'(PROBE_WAYS - 1));
               way_in      = way_ff + WBITS'(1);
            end
            if (cmp_vld_ff) begin
               if (srd_ff.key.valid && srd_ff.key.hash == hash_ff && !smatch_ff) begin
                  smatch_in = 1'b1;
                  sidx_in   = cmp_sidx_ff;
               end
               if (!srd_ff.key.valid && !sfound_ff) begin
                  sfound_in = 1'b1;
                  sfree_in  = cmp_sidx_ff;
               end
               if (cmp_last_ff) begin
                  way_in   = '0;
                  state_in = ST_AFIT;
               end
            end
         end
         ST_AFIT: begin
            if ((!smatch_ff && !sfound_ff) || (!amatch_ff && !afound_ff)) begin
               res_sts_in = STS_FULL;
               state_in   = ST_DONE;
            end else begin
               s_ra     = s_sel;
               a_ra     = aidx_ff;
               state_in = ST_AUPD;
            end
         end
         ST_AUPD: begin
            // credit the site, record the block, fetch the displaced block's site
            s_we           = 1'b1;
            s_wa           = s_sel;
            s_wd.key.valid = 1'b1;
            s_wd.key.hash  = hash_ff;
            s_wd.cnt       = crd_cnt;
            a_we           = 1'b1;
            a_wa           = a_sel;
            a_wd.tag.valid = 1'b1;
            a_wd.tag.addr  = addr_ff;
            a_wd.info.site = s_sel;
            a_wd.info.size = size_ff;
            a_wd.info.seq  = seq_ff;
            cnt_s_in    = crd_cnt;
            old_site_in = ard_ff.info.site;
            old_size_in = ard_ff.info.size;
            s_ra        = ard_ff.info.site;
            if (amatch_ff) begin
               state_in = ST_ADEBIT;
            end else begin
               res_sts_in = STS_RECORDED;
               res_cnt_in = crd_cnt;
               state_in   = ST_DONE;
            end
         end
         ST_ADEBIT: begin
            // forward the fresh credit when the old site is the same entry
            s_we        = 1'b1;
            s_wa        = old_site_ff;
            s_wd.key    = srd_ff.key;
            s_wd.cnt    = dbt_alloc;
            res_sts_in  = STS_RECORDED;
            res_recl_in = 1'b1;
            res_cnt_in  = (old_site_ff == s_sel) ? dbt_alloc : cnt_s_ff;
            state_in    = ST_DONE;
         end
         ST_FCHECK: begin
            if (!amatch_ff) begin
               res_sts_in = STS_UNKNOWN;
               state_in   = ST_DONE;
            end else begin
               a_ra     = aidx_ff;
               state_in = ST_FCNT;
            end
         end
         ST_FCNT: begin
            old_site_in = ard_ff.info.site;
            old_size_in = ard_ff.info.size;
            old_seq_in  = ard_ff.info.seq;
            s_ra        = ard_ff.info.site;
            state_in    = ST_FUPD;
         end
         ST_FUPD: begin
            if (seq_ff < old_seq_ff) begin
               res_sts_in = STS_STALE;
               res_cnt_in = srd_ff.cnt;
            end else begin
               s_we          = 1'b1;
               s_wa          = old_site_ff;
               s_wd.key      = srd_ff.key;
               s_wd.cnt      = dbt_free;
               a_we          = 1'b1;
               a_wa          = aidx_ff;
               a_wd.tag.addr = addr_ff;
               res_sts_in    = STS_FREE_HIT;
               res_cnt_in    = dbt_free;
            end
            state_in = ST_DONE;
         end
         ST_DONE: if (!rsp_valid_ff || rsp_chan.ready) begin
            rsp_valid_in = 1'b1;
            rsp_sts_in   = res_sts_ff;
            rsp_recl_in  = res_recl_ff;
            rsp_cnt_in   = res_cnt_ff;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      hash_ff     <= hash_in;
      seq_ff      <= seq_in;
      abase_ff    <= abase_in;
      sbase_ff    <= sbase_in;
      way_ff      <= way_in;
      cmp_last_ff <= cmp_last_in;
      cmp_aidx_ff <= cmp_aidx_in;
      cmp_sidx_ff <= cmp_sidx_in;
      amatch_ff   <= amatch_in;
      afound_ff   <= afound_in;
      aidx_ff     <= aidx_in;
      afree_ff    <= afree_in;
      smatch_ff   <= smatch_in;
      sfound_ff   <= sfound_in;
      sidx_ff     <= sidx_in;
      sfree_ff    <= sfree_in;
      old_site_ff <= old_site_in;
      old_size_ff <= old_size_in;
      old_seq_ff  <= old_seq_in;
      cnt_s_ff    <= cnt_s_in;
      res_sts_ff  <= res_sts_in;
      res_recl_ff <= res_recl_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_sts_ff  <= rsp_sts_in;
      rsp_recl_ff <= rsp_recl_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // table memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (a_we) amem[a_wa] <= a_wd;
      ard_ff <= amem[a_ra];
   end

   always_ff @(posedge clock) begin
      if (s_we) smem[s_wa] <= s_wd;
      srd_ff <= smem[s_ra];
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_sts_ff;
   assign rsp_chan.reclaimed_old    = rsp_recl_ff;
   assign rsp_chan.site_live_count  = rsp_cnt_ff.live_count;
   assign rsp_chan.site_live_bytes  = rsp_cnt_ff.live_bytes;
   assign rsp_chan.site_total_count = rsp_cnt_ff.total_count;
   assign rsp_chan.site_total_bytes = rsp_cnt_ff.total_bytes;

endmodule
`default_nettype wire
